### hdl/mbt_pkg.sv
// Shared types and constants of the 2-2-1 network trainer.
// Holds the sequencer step table, operand and action codes, register indexes.
// No dependencies.
`timescale 1ns / 1ps

package mbt_pkg;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    typedef enum logic [2:0] {
        ACT_MUL,
        ACT_MAC,
        ACT_ADDW,
        ACT_SIG,
        ACT_UPD,
        ACT_OUT
    } t_act;

    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_A,
        SRC_B,
        SRC_W,
        SRC_Y3,
        SRC_Y4,
        SRC_Y5,
        SRC_1MY3,
        SRC_1MY4,
        SRC_1MY5,
        SRC_EY,
        SRC_D5,
        SRC_D3,
        SRC_D4,
        SRC_LR,
        SRC_TMP
    } t_src;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_D5,
        DST_D3,
        DST_D4,
        DST_TMP,
        DST_Y3,
        DST_Y4,
        DST_Y5
    } t_dst;

    typedef struct packed {
        t_act       act;
        t_src       src_a;
        t_src       src_b;
        logic       a_is_acc;
        logic [3:0] widx;
        t_dst       dst;
    } t_step;

    // weight store layout
    localparam logic [3:0] W_13 = 4'd0;
    localparam logic [3:0] W_23 = 4'd1;
    localparam logic [3:0] W_14 = 4'd2;
    localparam logic [3:0] W_24 = 4'd3;
    localparam logic [3:0] W_35 = 4'd4;
    localparam logic [3:0] W_45 = 4'd5;
    localparam logic [3:0] B_3  = 4'd6;
    localparam logic [3:0] B_4  = 4'd7;
    localparam logic [3:0] B_5  = 4'd8;
    localparam int         N_WEIGHTS = 9;

    localparam logic [1:0] CFG_LR    = 2'd0;
    localparam logic [1:0] CFG_THR   = 2'd1;
    localparam logic [1:0] CFG_MAXEP = 2'd2;

    localparam logic [17:0] LR_RESET    = 18'd39322;
    localparam logic [23:0] THR_RESET   = 24'd66;
    localparam logic [19:0] MAXEP_RESET = 20'd1000000;

    localparam logic [5:0] ST_FWD_FIRST = 6'd0;
    localparam logic [5:0] ST_FWD_LAST  = 6'd11;
    localparam logic [5:0] ST_BP_FIRST  = 6'd12;
    localparam logic [5:0] ST_UPD_LAST  = 6'd32;
    localparam logic [5:0] ST_ERR       = 6'd33;
    localparam logic [5:0] ST_OUT       = 6'd34;

    function automatic t_step mk(input t_act act, input t_src sa, input t_src sb,
                                 input logic acc, input logic [3:0] w, input t_dst d);
        t_step s;
        s.act      = act;
        s.src_a    = sa;
        s.src_b    = sb;
        s.a_is_acc = acc;
        s.widx     = w;
        s.dst      = d;
        return s;
    endfunction

    function automatic t_step step_info(input logic [5:0] st);
        t_step s;
        unique case (st)
            6'd0:  s = mk(ACT_MUL,  SRC_A,    SRC_W,    1'b0, W_13, DST_NONE);
            6'd1:  s = mk(ACT_MAC,  SRC_B,    SRC_W,    1'b0, W_23, DST_NONE);
            6'd2:  s = mk(ACT_ADDW, SRC_ZERO, SRC_ZERO, 1'b0, B_3,  DST_NONE);
            6'd3:  s = mk(ACT_SIG,  SRC_ZERO, SRC_ZERO, 1'b0, W_13, DST_Y3);
            6'd4:  s = mk(ACT_MUL,  SRC_A,    SRC_W,    1'b0, W_14, DST_NONE);
            6'd5:  s = mk(ACT_MAC,  SRC_B,    SRC_W,    1'b0, W_24, DST_NONE);
            6'd6:  s = mk(ACT_ADDW, SRC_ZERO, SRC_ZERO, 1'b0, B_4,  DST_NONE);
            6'd7:  s = mk(ACT_SIG,  SRC_ZERO, SRC_ZERO, 1'b0, W_13, DST_Y4);
            6'd8:  s = mk(ACT_MUL,  SRC_Y3,   SRC_W,    1'b0, W_35, DST_NONE);
            6'd9:  s = mk(ACT_MAC,  SRC_Y4,   SRC_W,    1'b0, W_45, DST_NONE);
            6'd10: s = mk(ACT_ADDW, SRC_ZERO, SRC_ZERO, 1'b0, B_5,  DST_NONE);
            6'd11: s = mk(ACT_SIG,  SRC_ZERO, SRC_ZERO, 1'b0, W_13, DST_Y5);
            6'd12: s = mk(ACT_MUL,  SRC_Y5,   SRC_1MY5, 1'b0, W_13, DST_NONE);
            6'd13: s = mk(ACT_MUL,  SRC_ZERO, SRC_EY,   1'b1, W_13, DST_D5);
            6'd14: s = mk(ACT_MUL,  SRC_Y3,   SRC_1MY3, 1'b0, W_13, DST_NONE);
            6'd15: s = mk(ACT_MUL,  SRC_ZERO, SRC_D5,   1'b1, W_13, DST_NONE);
            6'd16: s = mk(ACT_MUL,  SRC_ZERO, SRC_W,    1'b1, W_35, DST_D3);
            6'd17: s = mk(ACT_MUL,  SRC_Y4,   SRC_1MY4, 1'b0, W_13, DST_NONE);
            6'd18: s = mk(ACT_MUL,  SRC_ZERO, SRC_D5,   1'b1, W_13, DST_NONE);
            6'd19: s = mk(ACT_MUL,  SRC_ZERO, SRC_W,    1'b1, W_45, DST_D4);
            6'd20: s = mk(ACT_MUL,  SRC_LR,   SRC_Y3,   1'b0, W_13, DST_TMP);
            6'd21: s = mk(ACT_UPD,  SRC_TMP,  SRC_D5,   1'b0, W_35, DST_NONE);
            6'd22: s = mk(ACT_MUL,  SRC_LR,   SRC_Y4,   1'b0, W_13, DST_TMP);
            6'd23: s = mk(ACT_UPD,  SRC_TMP,  SRC_D5,   1'b0, W_45, DST_NONE);
            6'd24: s = mk(ACT_UPD,  SRC_LR,   SRC_D5,   1'b0, B_5,  DST_NONE);
            6'd25: s = mk(ACT_MUL,  SRC_LR,   SRC_A,    1'b0, W_13, DST_TMP);
            6'd26: s = mk(ACT_UPD,  SRC_TMP,  SRC_D3,   1'b0, W_13, DST_NONE);
            6'd27: s = mk(ACT_UPD,  SRC_TMP,  SRC_D4,   1'b0, W_14, DST_NONE);
            6'd28: s = mk(ACT_MUL,  SRC_LR,   SRC_B,    1'b0, W_13, DST_TMP);
            6'd29: s = mk(ACT_UPD,  SRC_TMP,  SRC_D3,   1'b0, W_23, DST_NONE);
            6'd30: s = mk(ACT_UPD,  SRC_TMP,  SRC_D4,   1'b0, W_24, DST_NONE);
            6'd31: s = mk(ACT_UPD,  SRC_LR,   SRC_D3,   1'b0, B_3,  DST_NONE);
            6'd32: s = mk(ACT_UPD,  SRC_LR,   SRC_D4,   1'b0, B_4,  DST_NONE);
            6'd33: s = mk(ACT_MUL,  SRC_EY,   SRC_EY,   1'b0, W_13, DST_NONE);
            6'd34: s = mk(ACT_OUT,  SRC_ZERO, SRC_ZERO, 1'b0, W_13, DST_NONE);
            default: s = mk(ACT_OUT, SRC_ZERO, SRC_ZERO, 1'b0, W_13, DST_NONE);
        endcase
        return s;
    endfunction

endpackage

### hdl/mbt_in_if.sv
// Sample channel of the network trainer: valid, ready and one sample.
// Depends on nothing.
`timescale 1ns / 1ps

interface mbt_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] input_a;
    logic signed [23:0] input_b;
    logic [16:0]        target;
    logic               last_of_epoch;
    logic [3:0]         weight_index;

    modport source (output valid, input_a, input_b, target, last_of_epoch, weight_index,
                    input ready);
    modport sink   (input valid, input_a, input_b, target, last_of_epoch, weight_index,
                    output ready);
endinterface

### hdl/mbt_out_if.sv
// Result channel of the network trainer: valid, ready and one result.
// Depends on nothing.
`timescale 1ns / 1ps

interface mbt_out_if;
    logic               valid;
    logic               ready;
    logic [16:0]        prediction;
    logic [16:0]        sample_error_sq;
    logic [23:0]        epoch_error;
    logic               epoch_done;
    logic               converged;
    logic               trained;
    logic [19:0]        epochs_seen;
    logic signed [23:0] weight_value;

    modport source (output valid, prediction, sample_error_sq, epoch_error, epoch_done,
                    converged, trained, epochs_seen, weight_value, input ready);
    modport sink   (input valid, prediction, sample_error_sq, epoch_error, epoch_done,
                    converged, trained, epochs_seen, weight_value, output ready);
endinterface

### hdl/mlp_backprop_trainer_core.sv
// Top level of the 2-2-1 sigmoid network trainer with online gradient steps.
// Depends on mbt_pkg, mbt_in_if, mbt_out_if and mbt_ram.
`timescale 1ns / 1ps

// One sample at a time goes through a sequencer of steps around one shared multiplier and
// a nine-entry weight memory: each step reads a weight, forms one product and accumulates,
// looks up the sigmoid or writes the weight back. A training sample takes 47 steps (forward
// pass, deltas, nine updates, second forward pass, error and result); a sample taken while
// training is frozen or over its epoch limit takes 14 steps. The result sits in an output
// register, so the next sample is taken while it waits.
module mlp_backprop_trainer_core
    import mbt_pkg::*;
#(
    parameter int FRAC_BITS           = 16,
    parameter int WORD_BITS           = 24,
    parameter int SIGMOID_TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    mbt_in_if.sink      i_in,
    mbt_out_if.source   o_out
);
    localparam int OPW0  = (WORD_BITS > 24) ? WORD_BITS : 24;
    localparam int OPW1  = (OPW0 > 42 - FRAC_BITS) ? OPW0 : 42 - FRAC_BITS;
    localparam int OPW   = (OPW1 > FRAC_BITS + 2) ? OPW1 : FRAC_BITS + 2;
    localparam int PW    = 2 * OPW;
    localparam int ACW   = PW + 2;
    localparam int YW    = FRAC_BITS + 1;
    localparam int DBITS = $clog2(SIGMOID_TABLE_DEPTH);
    localparam int AW    = $clog2(N_WEIGHTS);
    localparam int SW    = FRAC_BITS + 4 + DBITS;

    localparam logic signed [OPW-1:0] ONE_OP  = OPW'(longint'(1) <<< FRAC_BITS);
    localparam logic signed [ACW-1:0] HALF_Q  = ACW'(longint'(1) <<< (FRAC_BITS - 1));
    localparam logic signed [ACW-1:0] LIM     = ACW'(longint'(8) <<< FRAC_BITS);
    localparam logic signed [ACW-1:0] NEG_LIM = -LIM;
    localparam logic signed [ACW-1:0] W_MAX   = ACW'((longint'(1) <<< (WORD_BITS - 1)) - 1);
    localparam logic signed [ACW-1:0] W_MIN   = -(ACW'(longint'(1) <<< (WORD_BITS - 1)));
    localparam logic signed [ACW-1:0] SQ_MAX  = ACW'(17'h1FFFF);
    localparam logic signed [ACW-1:0] SUM_MAX = ACW'(24'hFFFFFF);
    localparam logic [63:0]           Q31     = 64'd1 << 31;

    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        int          i;
        r = '0;
        q = '0;
        for (i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [YW-1:0] sig_entry(input int k);
        longint      m;
        logic [63:0] am;
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] s;
        int          i;
        m   = 2 * longint'(k) - longint'(SIGMOID_TABLE_DEPTH);
        am  = 64'(m < 0 ? -m : m);
        y   = udiv64(am << 30, 64'(SIGMOID_TABLE_DEPTH));
        t   = Q31;
        pos = Q31;
        neg = '0;
        for (i = 1; i <= 13; i++) begin
            t = udiv64((t * y) >> 31, 64'(i));
            if (i[0]) neg = neg + t;
            else      pos = pos + t;
        end
        e = (pos > neg) ? pos - neg : 64'd0;
        for (i = 0; i < 4; i++) begin
            e = (e * e + (64'd1 << 30)) >> 31;
        end
        den = Q31 + e;
        s   = udiv64((Q31 << FRAC_BITS) + (den >> 1), den);
        if (m < 0) s = (64'd1 << FRAC_BITS) - s;
        return YW'(s);
    endfunction

    function automatic logic signed [WORD_BITS-1:0] init_w(input int tenths);
        longint mag;
        longint v;
        longint hi;
        longint lo;
        mag = ((longint'(tenths < 0 ? -tenths : tenths) <<< FRAC_BITS) + 5) / 10;
        v   = (tenths < 0) ? -mag : mag;
        hi  = (longint'(1) <<< (WORD_BITS - 1)) - 1;
        lo  = -(longint'(1) <<< (WORD_BITS - 1));
        if (v > hi)      v = hi;
        else if (v < lo) v = lo;
        return WORD_BITS'(v);
    endfunction

    localparam logic signed [WORD_BITS-1:0] INIT_W [N_WEIGHTS] = '{
        init_w(5), init_w(4), init_w(9), init_w(10), init_w(-12),
        init_w(11), init_w(8), init_w(-1), init_w(3)
    };

    logic [YW-1:0] w_sig_tab [SIGMOID_TABLE_DEPTH];

    for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_sig
        localparam logic [YW-1:0] ENTRY = sig_entry(g);
        assign w_sig_tab[g] = ENTRY;
    end

    // control and training state
    t_state               r_state;
    logic [5:0]           r_step;
    logic [1:0]           r_phase;
    logic                 r_pass;
    logic                 r_train;
    logic [17:0]          r_lr;
    logic [23:0]          r_thr;
    logic [19:0]          r_maxep;
    logic [23:0]          r_epoch_sum;
    logic [19:0]          r_epoch_cnt;
    logic                 r_frozen;
    logic [N_WEIGHTS-1:0] r_wvld;
    logic                 r_out_valid;

    // datapath
    logic signed [23:0]     r_a;
    logic signed [23:0]     r_b;
    logic [YW-1:0]          r_t;
    logic                   r_last;
    logic [3:0]             r_sel;
    logic [YW-1:0]          r_y3;
    logic [YW-1:0]          r_y4;
    logic [YW-1:0]          r_y5;
    logic [YW-1:0]          r_pred;
    logic signed [OPW-1:0]  r_d5;
    logic signed [OPW-1:0]  r_d3;
    logic signed [OPW-1:0]  r_d4;
    logic signed [OPW-1:0]  r_tmp;
    logic signed [ACW-1:0]  r_acc;
    logic signed [PW-1:0]   r_prod;
    logic [DBITS-1:0]       r_sidx;
    logic [YW-1:0]          r_sig;
    logic                   r_rd_vld;
    logic [AW-1:0]          r_rd_addr;

    logic [16:0]        r_o_pred;
    logic [16:0]        r_o_sq;
    logic [23:0]        r_o_err;
    logic               r_o_done;
    logic               r_o_conv;
    logic               r_o_trained;
    logic [19:0]        r_o_cnt;
    logic signed [23:0] r_o_wv;

    t_step                       w_st;
    logic [AW-1:0]               w_raddr;
    logic [WORD_BITS-1:0]        w_ram_rdata;
    logic signed [WORD_BITS-1:0] w_rd;
    logic signed [OPW-1:0]       w_op_a;
    logic signed [OPW-1:0]       w_op_b;
    logic signed [ACW-1:0]       w_q;
    logic signed [ACW-1:0]       w_upd;
    logic signed [WORD_BITS-1:0] w_upd_sat;
    logic signed [ACW-1:0]       w_off;
    logic [SW-1:0]               w_scaled;
    logic [DBITS-1:0]            w_idx;
    logic                        w_ram_we;
    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_last_phase;
    logic                        w_finish;
    logic signed [ACW-1:0]       w_sq;
    logic [24:0]                 w_sum_add;
    logic [23:0]                 w_sum_new;
    logic [19:0]                 n_epoch_cnt;
    logic                        n_frozen;
    logic [23:0]                 n_epoch_sum;
    logic signed [32:0]          w_wv_wide;
    logic signed [23:0]          w_wv;

    assign w_st         = step_info(r_step);
    assign w_accept     = i_in.valid && i_in.ready;
    assign w_out_free   = !r_out_valid || o_out.ready;
    assign w_last_phase = (r_state == S_RUN) && (r_phase == 2'd2);
    assign w_finish     = w_last_phase && (w_st.act == ACT_OUT) && w_out_free;
    assign w_ram_we     = w_last_phase && (w_st.act == ACT_UPD);
    assign w_raddr      = (w_st.act == ACT_OUT) ?
                          ((r_sel < 4'(N_WEIGHTS)) ? AW'(r_sel) : AW'(0)) : AW'(w_st.widx);

    mbt_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (N_WEIGHTS)
    ) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (AW'(w_st.widx)),
        .i_wdata (w_upd_sat),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign w_rd = r_rd_vld ? signed'(w_ram_rdata) : INIT_W[r_rd_addr];

    function automatic logic signed [OPW-1:0] pick(input t_src src, input logic signed [23:0] a,
            input logic signed [23:0] b, input logic signed [WORD_BITS-1:0] w,
            input logic [YW-1:0] y3, input logic [YW-1:0] y4, input logic [YW-1:0] y5,
            input logic [YW-1:0] t, input logic signed [OPW-1:0] d5,
            input logic signed [OPW-1:0] d3, input logic signed [OPW-1:0] d4,
            input logic [17:0] lr, input logic signed [OPW-1:0] tmp);
        logic signed [OPW-1:0] v;
        case (src)
            SRC_A:    v = OPW'(a);
            SRC_B:    v = OPW'(b);
            SRC_W:    v = OPW'(w);
            SRC_Y3:   v = signed'(OPW'(y3));
            SRC_Y4:   v = signed'(OPW'(y4));
            SRC_Y5:   v = signed'(OPW'(y5));
            SRC_1MY3: v = ONE_OP - signed'(OPW'(y3));
            SRC_1MY4: v = ONE_OP - signed'(OPW'(y4));
            SRC_1MY5: v = ONE_OP - signed'(OPW'(y5));
            SRC_EY:   v = signed'(OPW'(t)) - signed'(OPW'(y5));
            SRC_D5:   v = d5;
            SRC_D3:   v = d3;
            SRC_D4:   v = d4;
            SRC_LR:   v = signed'(OPW'(lr));
            SRC_TMP:  v = tmp;
            default:  v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        w_op_a = pick(w_st.src_a, r_a, r_b, w_rd, r_y3, r_y4, r_y5, r_t, r_d5, r_d3, r_d4,
                      r_lr, r_tmp);
        if (w_st.a_is_acc) w_op_a = r_acc[OPW-1:0];
        w_op_b = pick(w_st.src_b, r_a, r_b, w_rd, r_y3, r_y4, r_y5, r_t, r_d5, r_d3, r_d4,
                      r_lr, r_tmp);
    end

    // rounded product, floor of (p + half) / 2^FRAC_BITS
    assign w_q   = (ACW'(r_prod) + HALF_Q) >>> FRAC_BITS;
    assign w_upd = ACW'(w_rd) + w_q;

    always_comb begin
        if (w_upd > W_MAX)      w_upd_sat = WORD_BITS'(W_MAX);
        else if (w_upd < W_MIN) w_upd_sat = WORD_BITS'(W_MIN);
        else                    w_upd_sat = WORD_BITS'(w_upd);
    end

    assign w_off    = r_acc + LIM;
    assign w_scaled = SW'(w_off[FRAC_BITS+3:0]) * SW'(SIGMOID_TABLE_DEPTH);

    always_comb begin
        if (r_acc < NEG_LIM)  w_idx = '0;
        else if (r_acc >= LIM) w_idx = DBITS'(SIGMOID_TABLE_DEPTH - 1);
        else                   w_idx = w_scaled[SW-1:FRAC_BITS+4];
    end

    // epoch bookkeeping at the end of the item
    always_comb begin
        w_sq      = (r_acc < 0) ? '0 : r_acc;
        w_sum_add = {1'b0, r_epoch_sum} + 25'(w_sq[23:0]);
        if (w_sq > SUM_MAX || w_sum_add > 25'hFFFFFF) w_sum_new = 24'hFFFFFF;
        else                                          w_sum_new = w_sum_add[23:0];
        n_epoch_cnt = r_epoch_cnt;
        n_frozen    = r_frozen;
        n_epoch_sum = r_epoch_sum;
        if (r_train) begin
            n_epoch_sum = w_sum_new;
            if (r_last) begin
                if (r_epoch_cnt != 20'hFFFFF) n_epoch_cnt = r_epoch_cnt + 20'd1;
                if (w_sum_new < r_thr)        n_frozen    = 1'b1;
                n_epoch_sum = '0;
            end
        end
        w_wv_wide = 33'(w_rd);
        if (r_sel >= 4'(N_WEIGHTS))           w_wv = '0;
        else if (w_wv_wide > 33'sd8388607)    w_wv = 24'sh7FFFFF;
        else if (w_wv_wide < -33'sd8388608)   w_wv = -24'sh800000;
        else                                  w_wv = w_wv_wide[23:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_FWD_FIRST;
            r_phase     <= 2'd0;
            r_pass      <= 1'b0;
            r_train     <= 1'b0;
            r_lr        <= LR_RESET;
            r_thr       <= THR_RESET;
            r_maxep     <= MAXEP_RESET;
            r_epoch_sum <= '0;
            r_epoch_cnt <= '0;
            r_frozen    <= 1'b0;
            r_wvld      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LR:    r_lr    <= i_cfg_data[17:0];
                    CFG_THR:   r_thr   <= i_cfg_data;
                    CFG_MAXEP: r_maxep <= i_cfg_data[19:0];
                    default: ;
                endcase
            end
            if (w_ram_we) r_wvld[AW'(w_st.widx)] <= 1'b1;
            if (r_out_valid && o_out.ready && !w_finish) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_RUN;
                        r_step  <= ST_FWD_FIRST;
                        r_phase <= 2'd0;
                        r_pass  <= 1'b0;
                        r_train <= !r_frozen && (r_epoch_cnt < r_maxep);
                    end
                end
                S_RUN: begin
                    if (r_phase != 2'd2) begin
                        r_phase <= r_phase + 2'd1;
                    end else if (w_st.act == ACT_OUT) begin
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_epoch_sum <= n_epoch_sum;
                            r_epoch_cnt <= n_epoch_cnt;
                            r_frozen    <= n_frozen;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_phase <= 2'd0;
                        if (r_step == ST_FWD_LAST) begin
                            r_step <= (!r_pass && r_train) ? ST_BP_FIRST : ST_ERR;
                        end else if (r_step == ST_UPD_LAST) begin
                            r_pass <= 1'b1;
                            r_step <= ST_FWD_FIRST;
                        end else begin
                            r_step <= r_step + 6'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_vld  <= r_wvld[w_raddr];
        r_rd_addr <= w_raddr;
        r_prod    <= w_op_a * w_op_b;
        r_sidx    <= w_idx;
        r_sig     <= w_sig_tab[r_sidx];
        if (w_accept) begin
            r_a    <= i_in.input_a;
            r_b    <= i_in.input_b;
            r_t    <= (32'(i_in.target) > (32'd1 << FRAC_BITS)) ?
                      YW'(32'd1 << FRAC_BITS) : YW'(i_in.target);
            r_last <= i_in.last_of_epoch;
            r_sel  <= i_in.weight_index;
        end
        if (w_last_phase) begin
            case (w_st.act)
                ACT_MUL:  r_acc <= w_q;
                ACT_MAC:  r_acc <= r_acc + w_q;
                ACT_ADDW: r_acc <= r_acc + ACW'(w_rd);
                default: ;
            endcase
            if (w_st.act == ACT_SIG) begin
                case (w_st.dst)
                    DST_Y3: r_y3 <= r_sig;
                    DST_Y4: r_y4 <= r_sig;
                    DST_Y5: r_y5 <= r_sig;
                    default: ;
                endcase
                if (w_st.dst == DST_Y5 && !r_pass) r_pred <= r_sig;
            end else begin
                case (w_st.dst)
                    DST_D5:  r_d5  <= w_q[OPW-1:0];
                    DST_D3:  r_d3  <= w_q[OPW-1:0];
                    DST_D4:  r_d4  <= w_q[OPW-1:0];
                    DST_TMP: r_tmp <= w_q[OPW-1:0];
                    default: ;
                endcase
            end
        end
        if (w_finish) begin
            r_o_pred    <= (32'(r_pred) > 32'h1FFFF) ? 17'h1FFFF : 17'(r_pred);
            r_o_sq      <= (w_sq > SQ_MAX) ? 17'h1FFFF : w_sq[16:0];
            r_o_err     <= r_train ? w_sum_new : r_epoch_sum;
            r_o_done    <= r_train && r_last;
            r_o_conv    <= n_frozen;
            r_o_trained <= r_train;
            r_o_cnt     <= n_epoch_cnt;
            r_o_wv      <= w_wv;
        end
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.prediction      = r_o_pred;
    assign o_out.sample_error_sq = r_o_sq;
    assign o_out.epoch_error     = r_o_err;
    assign o_out.epoch_done      = r_o_done;
    assign o_out.converged       = r_o_conv;
    assign o_out.trained         = r_o_trained;
    assign o_out.epochs_seen     = r_o_cnt;
    assign o_out.weight_value    = r_o_wv;
endmodule

### hdl/mbt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module mbt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 9
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/mbt_checker.sv
// Port-level checks of the network trainer, bound to its top level.
// Depends on mlp_backprop_trainer_core and its channel interfaces.
`timescale 1ns / 1ps

module mbt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [23:0] i_epoch_error,
    input logic        i_epoch_done,
    input logic        i_trained,
    input logic [19:0] i_epochs_seen
);
    // one sample in flight: ready drops right after a beat is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("sample taken while another is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_epoch_error)
                                           && $stable(i_epochs_seen)))
        else $error("stalled result beat changed");

    a_done_trained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_epoch_done) |-> i_trained)
        else $error("epoch closed by a sample that did not train");

    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_epoch_done) |-> (i_epochs_seen != 20'd0))
        else $error("epoch closed without counting");
endmodule

bind mlp_backprop_trainer_core mbt_checker u_mbt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_epoch_error (o_out.epoch_error),
    .i_epoch_done  (o_out.epoch_done),
    .i_trained     (o_out.trained),
    .i_epochs_seen (o_out.epochs_seen)
);
